// ===== hw/rtl/chm_pkg.sv =====
// Package for the cam phaser hot-stuck monitor.
// Holds the controller states, register indexes, command and status types and constants.
// It depends on nothing else.
package chm_pkg;

  localparam int CFG_W        = 16;
  localparam int CFG_ADDR_W   = 3;
  localparam int DIV_W        = 15;
  localparam int CNT_W        = 4;
  localparam int AMP_SCALE    = 75;
  localparam int OFFSET_SCALE = 3;
  localparam int DELAY_MAX    = 255;
  localparam int ANGLE_SHIFT  = 3;
  localparam int ANGLE_HALF   = 4;
  localparam int ANGLE_POS    = 127;
  localparam int ANGLE_NEG    = 128;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } chm_state_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SPEED_MIN       = 3'd0,
    REG_OIL_TEMP_MIN    = 3'd1,
    REG_AMPLITUDE_MIN   = 3'd2,
    REG_AMPLITUDE_GAIN  = 3'd3,
    REG_DELAY_OFFSET    = 3'd4,
    REG_BAND_LOW_LIMIT  = 3'd5,
    REG_BAND_HIGH_LIMIT = 3'd6,
    REG_DEVIATION_MIN   = 3'd7
  } chm_reg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } chm_cmd_t;

  typedef struct packed {
    logic div_last;
  } chm_sts_t;

endpackage

// ===== hw/rtl/cam_phaser_hot_stuck_monitor.sv =====
// Top level of the cam phaser hot-stuck monitor.
// Joins the controller chm_ctrl and the datapath chm_dp; it depends on chm_pkg.
//
// Each input item is one monitor tick; each tick gives exactly one result item.
// The input channel takes an item when in_valid is high and in_stall is low.
// The result channel offers an item on out_valid and moves it when out_stall is low.
// The configuration port writes register cfg_addr with cfg_wdata when cfg_we is high;
// the user must write only while no item is in flight; the block does not enforce it.
// An accepted item passes through a load step, fifteen steps of the bit-serial
// divider that forms amplitude*75/gain, and a commit step that waits for a free slot.
// A new item is taken only once the previous item has committed.
// The input is taken while an earlier result still waits to be moved. When the
// receiver stalls, the finished item waits in the commit stage and the result stays put.
// Reset clears every configuration register and all monitor state to zero, and
// leaves no result pending.
module cam_phaser_hot_stuck_monitor
  import chm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_servo_active,
  input  logic [15:0]           in_engine_speed,
  input  logic signed [15:0]    in_oil_temp_raw,
  input  logic [7:0]            in_setpoint_amplitude,
  input  logic                  in_inhibit,
  input  logic                  in_amplitude_varied,
  input  logic signed [15:0]    in_estimated_angle,
  input  logic signed [7:0]     in_start_angle,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_monitor_running,
  output logic                  out_stuck,
  output logic                  out_stuck_upper,
  output logic                  out_stuck_middle,
  output logic                  out_stuck_lower,
  output logic                  out_angle_read,
  output logic signed [7:0]     out_sampled_angle,
  output logic [7:0]            out_angle_deviation,
  output logic [7:0]            out_delay_ticks
);

  chm_cmd_t cmd;
  chm_sts_t sts;

  chm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  chm_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_addr              (cfg_addr),
    .cfg_wdata             (cfg_wdata),
    .in_servo_active       (in_servo_active),
    .in_engine_speed       (in_engine_speed),
    .in_oil_temp_raw       (in_oil_temp_raw),
    .in_setpoint_amplitude (in_setpoint_amplitude),
    .in_inhibit            (in_inhibit),
    .in_amplitude_varied   (in_amplitude_varied),
    .in_estimated_angle    (in_estimated_angle),
    .in_start_angle        (in_start_angle),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_monitor_running   (out_monitor_running),
    .out_stuck             (out_stuck),
    .out_stuck_upper       (out_stuck_upper),
    .out_stuck_middle      (out_stuck_middle),
    .out_stuck_lower       (out_stuck_lower),
    .out_angle_read        (out_angle_read),
    .out_sampled_angle     (out_sampled_angle),
    .out_angle_deviation   (out_angle_deviation),
    .out_delay_ticks       (out_delay_ticks)
  );

endmodule

// ===== hw/rtl/chm_ctrl.sv =====
// Controller of the cam phaser hot-stuck monitor.
// Sequences item load, the division steps and the commit, and owns the result valid.
// It depends on chm_pkg.
module chm_ctrl
  import chm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  chm_sts_t sts,
  output chm_cmd_t cmd
);

  chm_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
      end
      ST_FIN: begin
        cmd.commit = slot_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign out_valid_nxt = cmd.commit ? 1'b1 : (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_DIV)
    else $error("Accepted item did not start the division.");

  a_commit_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("Committed item did not raise the result valid.");

  a_blocked_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && out_valid_r && out_stall |=> state_r == ST_FIN && out_valid_r)
    else $error("Commit went ahead while the result slot was full.");

endmodule

// ===== hw/rtl/chm_dp.sv =====
// Datapath of the cam phaser hot-stuck monitor.
// Holds the registers, the held monitor state, the bit-serial delay divider and the update logic.
// It depends on chm_pkg.
module chm_dp
  import chm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_servo_active,
  input  logic [15:0]           in_engine_speed,
  input  logic signed [15:0]    in_oil_temp_raw,
  input  logic [7:0]            in_setpoint_amplitude,
  input  logic                  in_inhibit,
  input  logic                  in_amplitude_varied,
  input  logic signed [15:0]    in_estimated_angle,
  input  logic signed [7:0]     in_start_angle,
  input  chm_cmd_t              cmd,
  output chm_sts_t              sts,
  output logic                  out_monitor_running,
  output logic                  out_stuck,
  output logic                  out_stuck_upper,
  output logic                  out_stuck_middle,
  output logic                  out_stuck_lower,
  output logic                  out_angle_read,
  output logic signed [7:0]     out_sampled_angle,
  output logic [7:0]            out_angle_deviation,
  output logic [7:0]            out_delay_ticks
);

  logic [15:0]        speed_min_r;
  logic signed [13:0] oil_min_r;
  logic [7:0]         amp_min_r;
  logic [7:0]         gain_r;
  logic [7:0]         offset_r;
  logic signed [7:0]  band_lo_r;
  logic signed [7:0]  band_hi_r;
  logic signed [7:0]  dev_min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_min_r <= '0;
      oil_min_r   <= '0;
      amp_min_r   <= '0;
      gain_r      <= '0;
      offset_r    <= '0;
      band_lo_r   <= '0;
      band_hi_r   <= '0;
      dev_min_r   <= '0;
    end else if (cfg_we) begin
      case (chm_reg_t'(cfg_addr))
        REG_SPEED_MIN:       speed_min_r <= cfg_wdata;
        REG_OIL_TEMP_MIN:    oil_min_r   <= $signed(cfg_wdata[13:0]);
        REG_AMPLITUDE_MIN:   amp_min_r   <= cfg_wdata[7:0];
        REG_AMPLITUDE_GAIN:  gain_r      <= cfg_wdata[7:0];
        REG_DELAY_OFFSET:    offset_r    <= cfg_wdata[7:0];
        REG_BAND_LOW_LIMIT:  band_lo_r   <= $signed(cfg_wdata[7:0]);
        REG_BAND_HIGH_LIMIT: band_hi_r   <= $signed(cfg_wdata[7:0]);
        REG_DEVIATION_MIN:   dev_min_r   <= $signed(cfg_wdata[7:0]);
        default: begin
        end
      endcase
    end
  end

  // Activation conditions, evaluated on the input ports in the accept cycle.
  logic               oil_corr;
  logic signed [13:0] oil_scaled;
  logic               run_in;
  logic [DIV_W-1:0]   dividend;

  assign oil_corr   = in_oil_temp_raw[15] & (|in_oil_temp_raw[1:0]);
  assign oil_scaled = $signed(in_oil_temp_raw[15:2] + {13'd0, oil_corr});
  assign run_in     = in_servo_active && (in_engine_speed > speed_min_r) &&
                      (oil_scaled > oil_min_r) && (in_setpoint_amplitude > amp_min_r) &&
                      !in_inhibit;
  assign dividend   = {{(DIV_W-8){1'b0}}, in_setpoint_amplitude} * DIV_W'(AMP_SCALE);

  logic              run_l_r;
  logic              en_l_r;
  logic signed [15:0] est_r;
  logic signed [7:0]  start_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      run_l_r <= run_in;
      en_l_r  <= run_in && in_amplitude_varied;
      est_r   <= in_estimated_angle;
      start_r <= in_start_angle;
    end
  end

  // Restoring divider, one quotient bit per step.
  logic [DIV_W-1:0] quo_r;
  logic [7:0]       rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic [8:0]       trial;
  logic             trial_ge;

  assign trial    = {rem_r, quo_r[DIV_W-1]};
  assign trial_ge = trial >= {1'b0, gain_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r <= dividend;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.step) begin
      quo_r <= {quo_r[DIV_W-2:0], trial_ge};
      rem_r <= trial_ge ? 8'(trial - {1'b0, gain_r}) : trial[7:0];
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign sts.div_last = (cnt_r == CNT_W'(DIV_W - 1));

  // Held monitor state.
  logic              mon_r,      mon_nxt;
  logic              en_prev_r,  en_prev_nxt;
  logic [7:0]        timer_r,    timer_nxt;
  logic              read_r,     read_nxt;
  logic signed [7:0] angle_r,    angle_nxt;
  logic [7:0]        dev_r,      dev_nxt;
  logic [3:0]        flags_r,    flags_nxt;
  logic [7:0]        delay_r,    delay_nxt;

  logic [9:0]         off3;
  logic [15:0]        delay_sum;
  logic [7:0]         delay_calc;
  logic               edge_det;
  logic               counted;
  logic               expired;
  logic               sample;
  logic [15:0]        est_mag;
  logic [16:0]        est_rnd;
  logic [13:0]        rnd_mag;
  logic signed [7:0]  angle_new;
  logic signed [8:0]  diff;
  logic [8:0]         diff_abs;
  logic [7:0]         dev_new;
  logic               stuck_new;
  logic               stuck_b;

  assign off3       = {2'b00, offset_r} * 10'(OFFSET_SCALE);
  assign delay_sum  = {1'b0, quo_r} + {6'd0, off3};
  assign delay_calc = (gain_r == 8'd0 || delay_sum > 16'(DELAY_MAX)) ? 8'(DELAY_MAX)
                                                                      : delay_sum[7:0];
  assign edge_det   = !en_prev_r && en_l_r;

  assign est_mag  = est_r[15] ? 16'(-est_r) : est_r;
  assign est_rnd  = {1'b0, est_mag} + 17'(ANGLE_HALF);
  assign rnd_mag  = est_rnd[16:ANGLE_SHIFT];

  always_comb begin
    if (est_r[15]) begin
      angle_new = (rnd_mag > 14'(ANGLE_NEG)) ? $signed(8'h80) : $signed(~rnd_mag[7:0] + 8'd1);
    end else begin
      angle_new = (rnd_mag > 14'(ANGLE_POS)) ? $signed(8'h7F) : $signed(rnd_mag[7:0]);
    end
  end

  assign diff      = {angle_new[7], angle_new} - {start_r[7], start_r};
  assign diff_abs  = diff[8] ? 9'(-diff) : diff;
  assign dev_new   = diff_abs[7:0];
  assign stuck_new = $signed({1'b0, dev_new}) < $signed({dev_min_r[7], dev_min_r});

  always_comb begin
    counted   = 1'b0;
    expired   = 1'b0;
    timer_nxt = timer_r;
    if (edge_det) begin
      timer_nxt = delay_calc;
      counted   = 1'b1;
      expired   = (delay_calc == 8'd0);
    end else if (timer_r != 8'd0) begin
      timer_nxt = timer_r - 8'd1;
      counted   = 1'b1;
      expired   = (timer_r == 8'd1);
    end
  end

  assign sample = counted && expired && !read_r;

  always_comb begin
    mon_nxt     = run_l_r;
    en_prev_nxt = en_l_r;
    delay_nxt   = delay_r;
    read_nxt    = read_r;
    angle_nxt   = angle_r;
    dev_nxt     = dev_r;
    flags_nxt   = flags_r;
    stuck_b     = flags_r[0];
    if (run_l_r) begin
      delay_nxt = delay_calc;
      if (counted) begin
        read_nxt = expired;
      end
      if (sample) begin
        angle_nxt = angle_new;
        dev_nxt   = dev_new;
        stuck_b   = stuck_new;
      end
      flags_nxt[0] = stuck_b;
      flags_nxt[1] = stuck_b && (band_lo_r < angle_nxt);
      flags_nxt[2] = stuck_b && (band_lo_r >= angle_nxt) && (band_hi_r <= angle_nxt);
      flags_nxt[3] = stuck_b && (band_lo_r >= angle_nxt) && (band_hi_r > angle_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mon_r     <= 1'b0;
      en_prev_r <= 1'b0;
      timer_r   <= '0;
      read_r    <= 1'b0;
      angle_r   <= '0;
      dev_r     <= '0;
      flags_r   <= '0;
      delay_r   <= '0;
    end else if (cmd.commit) begin
      mon_r     <= mon_nxt;
      en_prev_r <= en_prev_nxt;
      delay_r   <= delay_nxt;
      read_r    <= read_nxt;
      angle_r   <= angle_nxt;
      dev_r     <= dev_nxt;
      flags_r   <= flags_nxt;
      if (run_l_r) begin
        timer_r <= timer_nxt;
      end
    end
  end

  assign out_monitor_running = mon_r;
  assign out_stuck           = flags_r[0];
  assign out_stuck_upper     = flags_r[1];
  assign out_stuck_middle    = flags_r[2];
  assign out_stuck_lower     = flags_r[3];
  assign out_angle_read      = read_r;
  assign out_sampled_angle   = angle_r;
  assign out_angle_deviation = dev_r;
  assign out_delay_ticks     = delay_r;

  a_bands_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(flags_r[3:1]))
    else $error("More than one stuck band is set.");

  a_band_needs_stuck: assert property (@(posedge clk) disable iff (!rst_n)
    (flags_r[3:1] != 3'b000) |-> flags_r[0])
    else $error("A stuck band is set without the stuck flag.");

  a_idle_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(flags_r) && $stable(angle_r) && $stable(timer_r))
    else $error("Monitor state changed outside a commit.");

endmodule
